// ===== rtl/core/xcfv_pkg.sv =====
// shared types and constants for the xor checked frame validator
package xcfv_pkg;

   localparam int BUFFER_BYTES_DEF = 256;

   localparam logic [7:0] SIGNATURE_RESET   = 8'hAC;
   localparam logic [7:0] CMD_LOWEST_RESET  = 8'hB1;
   localparam logic [7:0] CMD_HIGHEST_RESET = 8'hD8;

   localparam int MIN_FRAME_BYTES = 4;
   localparam int HEADER_BYTES    = 3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int RSP_DATA_W = 96;

   typedef enum logic [1:0] {
      REG_SIGNATURE   = 2'd0,
      REG_CMD_LOWEST  = 2'd1,
      REG_CMD_HIGHEST = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_KNOWN   = 3'd0,
      ST_UNKNOWN = 3'd1,
      ST_SHORT   = 3'd2,
      ST_BADSIG  = 3'd3,
      ST_TRUNC   = 3'd4,
      ST_CHKFAIL = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] signature;
      logic [7:0] cmd_lowest;
      logic [7:0] cmd_highest;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [7:0]  command_code;
      logic [7:0]  payload_length;
      logic [31:0] frames_accepted;
      logic [31:0] checksum_failures;
      logic [7:0]  latest_command;
   } result_type;

endpackage

// ===== rtl/core/xor_checked_frame_validator.sv =====
// top level: signature, length and xor checked frame validator
// a byte is registered on its req transfer and processed from the input register,
// where the last byte of a write loads the result register that drives rsp: the
// status passes through the input register and then the result register
// throughput one byte per cycle; only a held, untaken result stalls a last byte
// synchronous active-high reset clears frame state, counters and valid flags
// and loads the register defaults
module xor_checked_frame_validator #(
   parameter int BUFFER_BYTES = xcfv_pkg::BUFFER_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // byte stream in
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // data_byte
   input  logic                              req_tlast,   // last_of_write
   // status stream out
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[2:0], command_code[10:3], payload_length[18:11],
   // frames_accepted[50:19], checksum_failures[82:51], latest_command[90:83]
   output logic [xcfv_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [xcfv_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [xcfv_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [xcfv_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   xcfv_pkg::cfg_type    cfg;
   xcfv_pkg::result_type result;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;

   // result register
   logic                            out_valid_ff, out_valid_in;
   logic [xcfv_pkg::RSP_DATA_W-1:0] out_data_ff;

   logic out_free;
   logic stage_fire;
   logic req_xfer;

   xcfv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // result slot is free when empty or being taken this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   // a non-last byte never waits on the result side
   assign stage_fire = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || stage_fire;
   assign req_xfer   = req_tvalid && req_tready;

   xcfv_parse #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (stage_fire),
      .byte_data (in_data_ff),
      .byte_last (in_last_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign in_valid_in  = req_xfer || (in_valid_ff && !stage_fire);
   assign out_valid_in = result.valid || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (result.valid) begin
         out_data_ff <= {5'd0,
                         result.latest_command,
                         result.checksum_failures,
                         result.frames_accepted,
                         result.payload_length,
                         result.command_code,
                         result.status};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // a held result must never be overwritten by a new frame end
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !result.valid)
      else $error("result register overwritten while held");

   // a last byte waits while the result slot is busy
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && out_valid_ff && !rsp_tready) |-> !stage_fire)
      else $error("last byte processed into a busy result slot");

   // a loaded result is presented on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      result.valid |=> rsp_tvalid)
      else $error("loaded result not presented");

   // status codes above checksum mismatch are never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= 3'd5))
      else $error("status code out of range");

endmodule

// ===== rtl/core/xcfv_csr.sv =====
// configuration registers behind the apb-style port
module xcfv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [xcfv_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [xcfv_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [xcfv_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output xcfv_pkg::cfg_type                   cfg
);

   xcfv_pkg::cfg_type cfg_ff;
   xcfv_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            xcfv_pkg::REG_SIGNATURE:   cfg_in.signature   = csr_pwdata[7:0];
            xcfv_pkg::REG_CMD_LOWEST:  cfg_in.cmd_lowest  = csr_pwdata[7:0];
            xcfv_pkg::REG_CMD_HIGHEST: cfg_in.cmd_highest = csr_pwdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signature   <= xcfv_pkg::SIGNATURE_RESET;
         cfg_ff.cmd_lowest  <= xcfv_pkg::CMD_LOWEST_RESET;
         cfg_ff.cmd_highest <= xcfv_pkg::CMD_HIGHEST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         xcfv_pkg::REG_SIGNATURE:   csr_prdata = {24'd0, cfg_ff.signature};
         xcfv_pkg::REG_CMD_LOWEST:  csr_prdata = {24'd0, cfg_ff.cmd_lowest};
         xcfv_pkg::REG_CMD_HIGHEST: csr_prdata = {24'd0, cfg_ff.cmd_highest};
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/xcfv_parse.sv =====
// per-byte frame tracking, status decision and frame counters
module xcfv_parse #(
   parameter int BUFFER_BYTES = xcfv_pkg::BUFFER_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_fire,
   input  logic [7:0]           byte_data,
   input  logic                 byte_last,
   input  xcfv_pkg::cfg_type    cfg,
   output xcfv_pkg::result_type result
);

   localparam int POS_W = $clog2(BUFFER_BYTES + 1);
   localparam int CMP_W = ((POS_W > 8) ? POS_W : 8) + 1;

   logic [POS_W-1:0] pos_ff, pos_in, pos_nx;
   logic [7:0]       xor_ff, xor_in, xor_nx;
   logic [7:0]       first_ff, first_in, first_nx;
   logic [7:0]       cmd_ff, cmd_in, cmd_nx;
   logic [7:0]       len_ff, len_in, len_nx;
   logic             seen_ff, seen_in, seen_nx;
   logic             match_ff, match_in, match_nx;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      fail_ff, fail_in;
   logic [7:0]       recent_ff, recent_in;
   logic [CMP_W-1:0] pos_ext, check_pos;
   xcfv_pkg::status_type status;

   assign pos_ext   = CMP_W'(pos_ff);
   assign check_pos = CMP_W'(xcfv_pkg::HEADER_BYTES) + CMP_W'(len_ff);

   // frame state after taking this byte
   always_comb begin
      pos_nx   = pos_ff;
      xor_nx   = xor_ff;
      first_nx = first_ff;
      cmd_nx   = cmd_ff;
      len_nx   = len_ff;
      seen_nx  = seen_ff;
      match_nx = match_ff;
      if (pos_ff < POS_W'(BUFFER_BYTES)) begin
         pos_nx = pos_ff + POS_W'(1);
         if (pos_ff == POS_W'(0)) begin
            first_nx = byte_data;
         end else if (pos_ff == POS_W'(1)) begin
            cmd_nx = byte_data;
            xor_nx = xor_ff ^ byte_data;
         end else if (pos_ff == POS_W'(2)) begin
            len_nx = byte_data;
            xor_nx = xor_ff ^ byte_data;
         end else if (pos_ext < check_pos) begin
            xor_nx = xor_ff ^ byte_data;
         end else if (pos_ext == check_pos) begin
            seen_nx  = 1'b1;
            match_nx = (byte_data == xor_ff);
         end
      end
   end

   // status of a frame ending on this byte
   always_comb begin
      acc_in    = acc_ff;
      fail_in   = fail_ff;
      recent_in = recent_ff;
      if (pos_nx < POS_W'(xcfv_pkg::MIN_FRAME_BYTES)) begin
         status = xcfv_pkg::ST_SHORT;
      end else if (first_nx != cfg.signature) begin
         status = xcfv_pkg::ST_BADSIG;
      end else if (!seen_nx) begin
         status = xcfv_pkg::ST_TRUNC;
      end else if (!match_nx) begin
         status  = xcfv_pkg::ST_CHKFAIL;
         fail_in = fail_ff + 32'd1;
      end else begin
         acc_in    = acc_ff + 32'd1;
         recent_in = cmd_nx;
         if (cmd_nx >= cfg.cmd_lowest && cmd_nx <= cfg.cmd_highest) begin
            status = xcfv_pkg::ST_KNOWN;
         end else begin
            status = xcfv_pkg::ST_UNKNOWN;
         end
      end
   end

   // write state is cleared once the last byte is taken
   always_comb begin
      pos_in   = pos_nx;
      xor_in   = xor_nx;
      first_in = first_nx;
      cmd_in   = cmd_nx;
      len_in   = len_nx;
      seen_in  = seen_nx;
      match_in = match_nx;
      if (byte_last) begin
         pos_in   = '0;
         xor_in   = '0;
         first_in = '0;
         cmd_in   = '0;
         len_in   = '0;
         seen_in  = 1'b0;
         match_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         xor_ff    <= '0;
         first_ff  <= '0;
         cmd_ff    <= '0;
         len_ff    <= '0;
         seen_ff   <= 1'b0;
         match_ff  <= 1'b0;
         acc_ff    <= '0;
         fail_ff   <= '0;
         recent_ff <= '0;
      end else if (byte_fire) begin
         pos_ff   <= pos_in;
         xor_ff   <= xor_in;
         first_ff <= first_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         match_ff <= match_in;
         if (byte_last) begin
            acc_ff    <= acc_in;
            fail_ff   <= fail_in;
            recent_ff <= recent_in;
         end
      end
   end

   assign result.valid             = byte_fire && byte_last;
   assign result.status            = status;
   assign result.command_code      = cmd_nx;
   assign result.payload_length    = len_nx;
   assign result.frames_accepted   = acc_in;
   assign result.checksum_failures = fail_in;
   assign result.latest_command    = recent_in;

endmodule
